@@ design/ymodem_data_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// ymodem_data_receiver_defines - assertion macros
// Shared concurrent assertion forms for the YMODEM data receiver.
// ----------------------------------------------------------------------------
`ifndef YMODEM_DATA_RECEIVER_DEFINES_SVH
`define YMODEM_DATA_RECEIVER_DEFINES_SVH

// same-cycle implication
`define YMDR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ymodem_data_receiver: assertion failed");

// next-cycle implication
`define YMDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ymodem_data_receiver: assertion failed");

`endif

@@ design/ymdr_pkg.sv @@
// ----------------------------------------------------------------------------
// ymdr_pkg - YMODEM data receiver package
// Codes, types and the byte-wide CRC-16/XMODEM update.
// ----------------------------------------------------------------------------
package ymdr_pkg;

  localparam int QUEUE_DEPTH = 4;

  // commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // control characters
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_CRC   = 8'h43;
  localparam logic [7:0] CH_ABORT = 8'h41;
  localparam logic [7:0] CH_ABORT_LC = 8'h61;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [4:0]  ERROR_LIMIT_RESET = 5'd5;

  // verdicts
  localparam logic [1:0] V_NONE    = 2'd0;
  localparam logic [1:0] V_COMMIT  = 2'd1;
  localparam logic [1:0] V_DISCARD = 2'd2;
  localparam logic [1:0] V_HEADER  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RECEIVING = 3'd1,
    PH_EOT       = 3'd2,
    PH_CANCELLED = 3'd3,
    PH_ABORT     = 3'd4,
    PH_ERRORS    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    FS_START  = 3'd0,
    FS_CAN    = 3'd1,
    FS_BLKNUM = 3'd2,
    FS_BLKCMP = 3'd3,
    FS_DATA   = 3'd4,
    FS_CRC_HI = 3'd5,
    FS_CRC_LO = 3'd6
  } step_t;

  // one queued transaction: everything the back end needs for 1 or 2 results
  typedef struct packed {
    logic [1:0]  nrep;
    logic [7:0]  rep0;
    logic [7:0]  rep1;
    logic        pay;
    logic [7:0]  pbyte;
    logic [1:0]  verdict;
    logic [31:0] total;
    phase_t      phase;
  } desc_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ design/ymdr_front.sv @@
// ----------------------------------------------------------------------------
// ymdr_front - framing and session front end
// Takes commands, runs block framing, CRC and session rules, queues results.
// ----------------------------------------------------------------------------
`include "ymodem_data_receiver_defines.svh"

module ymdr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_limit,
  input  logic              q_full,
  output logic              q_push,
  output ymdr_pkg::desc_t   q_data
);
  import ymdr_pkg::*;

  phase_t      phase, phase_next;
  step_t       step, step_next;
  logic [4:0]  limit;
  logic        long_block, long_block_next;
  logic [10:0] bytes_left, bytes_left_next;
  logic [7:0]  block_number, block_number_next;
  logic [7:0]  block_complement, block_complement_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  crc_high, crc_high_next;
  logic [7:0]  expected, expected_next;
  logic [4:0]  error_count, error_count_next;
  logic [31:0] total, total_next;

  logic accept, active, is_start, is_byte, is_tmo;
  logic hdr, eot, can, abort, blk_bad, err, over, notify;
  desc_t d;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;
  assign active    = (phase == PH_RECEIVING);
  assign is_start  = accept && (command == CMD_START);
  assign is_byte   = accept && active && (command == CMD_BYTE);
  assign is_tmo    = accept && active && (command == CMD_TIMEOUT);

  assign hdr   = (rx_byte == CH_SOH) || (rx_byte == CH_STX);
  assign eot   = (rx_byte == CH_EOT);
  assign can   = (rx_byte == CH_CAN);
  assign abort = (rx_byte == CH_ABORT) || (rx_byte == CH_ABORT_LC);
  assign blk_bad = (block_number != ~block_complement) ||
                   ({crc_high, rx_byte} != crc_accum);

  assign err = is_tmo ||
               (is_byte && (((step == FS_START) && !(hdr || eot || can || abort)) ||
                            ((step == FS_CAN) && !can) ||
                            ((step == FS_CRC_LO) && blk_bad)));
  assign over = err && (error_count >= limit);

  // next state: session phase and framing step
  always_comb begin
    phase_next = phase;
    step_next  = step;
    if (is_start) begin
      phase_next = PH_RECEIVING;
      step_next  = FS_START;
    end else if (err) begin
      step_next = FS_START;
      if (over) phase_next = PH_ERRORS;
    end else if (is_byte) begin
      unique case (step)
        FS_START: begin
          if (hdr) step_next = FS_BLKNUM;
          else if (eot) phase_next = PH_EOT;
          else if (can) step_next = FS_CAN;
          else if (abort) phase_next = PH_ABORT;
        end
        FS_CAN: begin
          phase_next = PH_CANCELLED;
          step_next  = FS_START;
        end
        FS_BLKNUM: step_next = FS_BLKCMP;
        FS_BLKCMP: step_next = FS_DATA;
        FS_DATA:   if (bytes_left == 11'd1) step_next = FS_CRC_HI;
        FS_CRC_HI: step_next = FS_CRC_LO;
        FS_CRC_LO: step_next = FS_START;
        default:   step_next = FS_START;
      endcase
    end
  end

  // datapath and queued result
  always_comb begin
    long_block_next       = long_block;
    bytes_left_next       = bytes_left;
    block_number_next     = block_number;
    block_complement_next = block_complement;
    crc_accum_next        = crc_accum;
    crc_high_next         = crc_high;
    expected_next         = expected;
    error_count_next      = error_count;
    total_next            = total;
    notify                = 1'b0;
    d                     = '0;
    if (is_start) begin
      expected_next    = 8'd1;
      error_count_next = 5'd0;
      total_next       = 32'd0;
      d.nrep = 2'd2;
      d.rep0 = CH_ACK;
      d.rep1 = CH_CRC;
    end else if (err) begin
      if (over) begin
        d.nrep = 2'd2;
        d.rep0 = CH_CAN;
        d.rep1 = CH_CAN;
      end else begin
        error_count_next = error_count + 5'd1;
        d.nrep = 2'd1;
        d.rep0 = CH_NAK;
      end
      // a timeout inside a block, or a bad block, discards it
      if ((is_tmo && (step >= FS_BLKNUM)) || (is_byte && (step == FS_CRC_LO)))
        d.verdict = V_DISCARD;
    end else if (is_byte) begin
      case (step)
        FS_START: begin
          if (hdr) begin
            long_block_next = (rx_byte == CH_STX);
            bytes_left_next = (rx_byte == CH_STX) ? 11'd1024 : 11'd128;
            crc_accum_next  = 16'd0;
          end else if (eot) begin
            notify = 1'b1;
          end else if (abort) begin
            d.nrep = 2'd2;
            d.rep0 = CH_CAN;
            d.rep1 = CH_CAN;
          end
        end
        FS_CAN: begin
          error_count_next = 5'd0;
          d.nrep = 2'd1;
          d.rep0 = CH_ACK;
        end
        FS_BLKNUM: block_number_next = rx_byte;
        FS_BLKCMP: block_complement_next = rx_byte;
        FS_DATA: begin
          d.pay           = 1'b1;
          d.pbyte         = rx_byte;
          crc_accum_next  = crc16_byte(crc_accum, rx_byte);
          bytes_left_next = bytes_left - 11'd1;
        end
        FS_CRC_HI: crc_high_next = rx_byte;
        FS_CRC_LO: begin
          error_count_next = 5'd0;
          d.nrep = 2'd1;
          d.rep0 = CH_ACK;
          if (block_number == 8'd0) begin
            // header block sent again
            d.verdict = V_HEADER;
            d.nrep    = 2'd2;
            d.rep1    = CH_CRC;
          end else if (block_number == expected) begin
            d.verdict     = V_COMMIT;
            total_next    = total + (long_block ? 32'd1024 : 32'd128);
            expected_next = expected + 8'd1;
          end else if (block_number == expected - 8'd1) begin
            d.verdict = V_DISCARD;
          end else begin
            d.verdict = V_DISCARD;
            d.rep0    = CH_NAK;
          end
        end
        default: ;
      endcase
    end
    d.total = total_next;
    d.phase = phase_next;
  end

  assign q_push = accept && ((d.nrep != 2'd0) || d.pay || notify || (d.verdict != V_NONE));
  assign q_data = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      step             <= FS_START;
      limit            <= ERROR_LIMIT_RESET;
      long_block       <= 1'b0;
      bytes_left       <= 11'd0;
      block_number     <= 8'd0;
      block_complement <= 8'd0;
      crc_accum        <= 16'd0;
      crc_high         <= 8'd0;
      expected         <= 8'd1;
      error_count      <= 5'd0;
      total            <= 32'd0;
    end else begin
      if (cfg_valid) limit <= cfg_limit;
      phase            <= phase_next;
      step             <= step_next;
      long_block       <= long_block_next;
      bytes_left       <= bytes_left_next;
      block_number     <= block_number_next;
      block_complement <= block_complement_next;
      crc_accum        <= crc_accum_next;
      crc_high         <= crc_high_next;
      expected         <= expected_next;
      error_count      <= error_count_next;
      total            <= total_next;
    end
  end

  `YMDR_ASSERT_IMP(a_idle_framing, clk, rst, phase != PH_RECEIVING, step == FS_START)
  `YMDR_ASSERT_NEXT(a_start_fresh, clk, rst, is_start, (phase == PH_RECEIVING) && (error_count == 5'd0) && (expected == 8'd1) && (total == 32'd0))

endmodule

@@ design/ymdr_queue.sv @@
// ----------------------------------------------------------------------------
// ymdr_queue - result descriptor queue
// Small flop-based FIFO between the front end and the output stage.
// ----------------------------------------------------------------------------
`include "ymodem_data_receiver_defines.svh"

module ymdr_queue #(
  parameter int DEPTH = ymdr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ymdr_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output ymdr_pkg::desc_t head,
  output logic            head_valid
);
  import ymdr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full)
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop && head_valid)
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      count <= count + CW'(push && !full) - CW'(pop && head_valid);
    end
  end

  `YMDR_ASSERT_IMP(a_no_overflow, clk, rst, push, !full)
  `YMDR_ASSERT_IMP(a_no_underflow, clk, rst, pop, head_valid)

endmodule

@@ design/ymdr_back.sv @@
// ----------------------------------------------------------------------------
// ymdr_back - result output stage
// Expands each queued descriptor into one or two registered result items.
// ----------------------------------------------------------------------------
`include "ymodem_data_receiver_defines.svh"

module ymdr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ymdr_pkg::desc_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            reply_valid,
  output logic [7:0]      reply_byte,
  output logic            payload_valid,
  output logic [7:0]      payload_byte,
  output logic [1:0]      verdict,
  output logic [31:0]     bytes_committed,
  output logic [2:0]      session_state,
  output logic            last
);
  import ymdr_pkg::*;

  logic sub;   // second result of the head descriptor is next
  logic load, two;

  assign load = (!out_valid || out_ready) && head_valid;
  assign two  = (head.nrep == 2'd2);
  assign pop  = load && (!two || sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= two && !sub;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_committed <= head.total;
      session_state   <= head.phase;
      if (sub) begin
        reply_valid   <= 1'b1;
        reply_byte    <= head.rep1;
        payload_valid <= 1'b0;
        payload_byte  <= 8'd0;
        verdict       <= V_NONE;
        last          <= 1'b1;
      end else begin
        reply_valid   <= (head.nrep != 2'd0);
        reply_byte    <= (head.nrep != 2'd0) ? head.rep0 : 8'd0;
        payload_valid <= head.pay;
        payload_byte  <= head.pay ? head.pbyte : 8'd0;
        verdict       <= head.verdict;
        last          <= !two;
      end
    end
  end

  `YMDR_ASSERT_IMP(a_second_pending, clk, rst, sub, out_valid && !last)

endmodule

@@ design/ymodem_data_receiver.sv @@
// A result item passes through the descriptor queue and then the output register after its command is accepted.
// Throughput: one command per cycle while the queue has room; one result per cycle out of the output
//   register while out_ready is high, so a command with two replies takes two result transactions.
// The QUEUE_DEPTH descriptor queue between front end and output stage sets how long
//   input keeps flowing while the output is stalled.
// Reset (rst, synchronous, active high): session idle, framing cleared, error_limit 5.
// ----------------------------------------------------------------------------
// ymodem_data_receiver - YMODEM data-phase receiver
// Frames SOH/STX blocks, checks number and CRC-16, replies ACK/NAK/CA/'C'.
// ----------------------------------------------------------------------------
module ymodem_data_receiver #(
  parameter int QUEUE_DEPTH = ymdr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reply_valid,
  output logic [7:0]  reply_byte,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [1:0]  verdict,
  output logic [31:0] bytes_committed,
  output logic [2:0]  session_state,
  output logic        last,
  // configuration channel: error_limit register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  error_limit
);
  import ymdr_pkg::*;

  // Front end: one command per transaction, full state update in the same cycle.
  // It only stalls when the queue has no room.
  desc_t q_data, q_head;
  logic  q_push, q_full, q_pop, q_valid;

  ymdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_limit (error_limit),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // Descriptors for commands that produce at least one result.
  ymdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  // Output register; splits two-reply descriptors into two result transactions.
  ymdr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (q_valid),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .reply_valid     (reply_valid),
    .reply_byte      (reply_byte),
    .payload_valid   (payload_valid),
    .payload_byte    (payload_byte),
    .verdict         (verdict),
    .bytes_committed (bytes_committed),
    .session_state   (session_state),
    .last            (last)
  );

endmodule

@@ tb/tb_ymodem_data_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_ymodem_data_receiver - testbench for the YMODEM data-phase receiver
// Drives start/byte/timeout commands with random gaps, stalls the result side
// at random, predicts every result (replies, tentative payload, verdicts,
// committed byte count, session state) and compares them field by field.
// ----------------------------------------------------------------------------
module tb_ymodem_data_receiver;
  import ymdr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;   // reserved command, must be ignored
  localparam int SHORT_LEN    = 128;
  localparam int LONG_LEN     = 1024;
  localparam int WAIT_TOP     = 12;           // longest sender gap / receiver stall
  localparam int DRAIN_CYCLES = 12;           // generous margin past queue and output register
  localparam int IDLE_LIMIT   = 1000;         // cycles with no transaction at all
  localparam int RANDOM_ITEMS = 1550;

  typedef enum {
    BK_GOOD, BK_HEADER, BK_DUP, BK_WRONG_NUM, BK_BAD_CMP, BK_BAD_CRC, BK_TIMEOUT
  } block_kind_t;

  // one result transaction as seen on the output port
  typedef struct packed {
    logic        reply_v;
    logic [7:0]  reply_b;
    logic        pay_v;
    logic [7:0]  pay_b;
    logic [1:0]  vrd;
    logic [31:0] total;
    logic [2:0]  state;
    logic        last;
  } rx_out_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the receiver state and the queue of
  // results still owed by the DUT.
  // --------------------------------------------------------------------------
  class receiver_scoreboard;
    phase_t      phase;
    step_t       step;
    bit          long_blk;
    bit [10:0]   left;
    bit [7:0]    blk_num;
    bit [7:0]    blk_cmp;
    bit [15:0]   crc;
    bit [7:0]    crc_hi;
    bit [7:0]    want_blk;
    bit [4:0]    errs;
    bit [4:0]    err_limit;
    bit [31:0]   total;
    bit [7:0]    replies[$];
    rx_out_t     due[$];
    int unsigned fails, taken, checked, commits, discards, headers;

    function new();
      phase     = PH_IDLE;
      step      = FS_START;
      long_blk  = 1'b0;
      left      = '0;
      blk_num   = '0;
      blk_cmp   = '0;
      crc       = '0;
      crc_hi    = '0;
      want_blk  = 8'd1;
      errs      = '0;
      err_limit = ERROR_LIMIT_RESET;
      total     = '0;
    endfunction

    // CRC-16/XMODEM, one bit at a time, MSB first
    static function bit [15:0] crc_step(bit [15:0] c, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void add_reply(bit [7:0] r);
      if (replies.size() < 2) replies.push_back(r);
    endfunction

    function void count_error();
      if (errs >= err_limit) begin
        add_reply(CH_CAN);
        add_reply(CH_CAN);
        phase = PH_ERRORS;
      end else begin
        errs = errs + 5'd1;
        add_reply(CH_NAK);
      end
      step = FS_START;
    endfunction

    // advance the receiver by one accepted command and queue its results
    function void note_command(logic [1:0] cmd, logic [7:0] b);
      bit      pay, notify;
      bit [1:0] vrd;
      int      n, k;
      rx_out_t o;
      replies.delete();
      pay    = 1'b0;
      notify = 1'b0;
      vrd    = V_NONE;
      if (cmd == CMD_START) begin
        phase    = PH_RECEIVING;
        step     = FS_START;
        want_blk = 8'd1;
        errs     = '0;
        total    = '0;
        add_reply(CH_ACK);
        add_reply(CH_CRC);
      end else if (cmd == CMD_UNUSED || phase != PH_RECEIVING) begin
        return;
      end else if (cmd == CMD_TIMEOUT) begin
        if (step >= FS_BLKNUM) vrd = V_DISCARD;
        count_error();
      end else begin
        case (step)
          FS_START: begin
            if (b == CH_SOH || b == CH_STX) begin
              long_blk = (b == CH_STX);
              left     = long_blk ? 11'(LONG_LEN) : 11'(SHORT_LEN);
              crc      = '0;
              step     = FS_BLKNUM;
            end else if (b == CH_EOT) begin
              phase  = PH_EOT;
              notify = 1'b1;
            end else if (b == CH_CAN) begin
              step = FS_CAN;
            end else if (b == CH_ABORT || b == CH_ABORT_LC) begin
              add_reply(CH_CAN);
              add_reply(CH_CAN);
              phase = PH_ABORT;
            end else begin
              count_error();
            end
          end
          FS_CAN: begin
            if (b == CH_CAN) begin
              errs  = '0;
              add_reply(CH_ACK);
              phase = PH_CANCELLED;
              step  = FS_START;
            end else begin
              count_error();
            end
          end
          FS_BLKNUM: begin
            blk_num = b;
            step    = FS_BLKCMP;
          end
          FS_BLKCMP: begin
            blk_cmp = b;
            step    = FS_DATA;
          end
          FS_DATA: begin
            pay  = 1'b1;
            crc  = crc_step(crc, b);
            left = left - 11'd1;
            if (left == 0) step = FS_CRC_HI;
          end
          FS_CRC_HI: begin
            crc_hi = b;
            step   = FS_CRC_LO;
          end
          default: begin
            step = FS_START;
            if (blk_num != ~blk_cmp || {crc_hi, b} != crc) begin
              vrd = V_DISCARD;
              count_error();
            end else begin
              errs = '0;
              if (blk_num == 8'd0) begin
                vrd = V_HEADER;
                add_reply(CH_ACK);
                add_reply(CH_CRC);
              end else if (blk_num == want_blk) begin
                vrd      = V_COMMIT;
                total    = total + (long_blk ? LONG_LEN : SHORT_LEN);
                want_blk = want_blk + 8'd1;
                add_reply(CH_ACK);
              end else if (blk_num == want_blk - 8'd1) begin
                vrd = V_DISCARD;        // duplicate: ACK it, drop the data
                add_reply(CH_ACK);
              end else begin
                vrd = V_DISCARD;
                add_reply(CH_NAK);
              end
            end
          end
        endcase
      end

      taken++;
      case (vrd)
        V_COMMIT:  commits++;
        V_DISCARD: discards++;
        V_HEADER:  headers++;
        default: ;
      endcase
      n = replies.size();
      if (n == 0 && (pay || notify || vrd != V_NONE)) n = 1;
      for (k = 0; k < n; k++) begin
        o.reply_v = (k < replies.size());
        o.reply_b = (k < replies.size()) ? replies[k] : 8'h00;
        o.pay_v   = (k == 0) && pay;
        o.pay_b   = ((k == 0) && pay) ? b : 8'h00;
        o.vrd     = (k == 0) ? vrd : V_NONE;
        o.total   = total;
        o.state   = phase;
        o.last    = (k == n - 1);
        due.push_back(o);
      end
    endfunction

    task report(string msg);
      fails++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_output(rx_out_t got);
      rx_out_t want;
      if (due.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      want = due.pop_front();
      checked++;
      cmp_field("reply_valid", 32'(got.reply_v), 32'(want.reply_v));
      cmp_field("reply_byte", 32'(got.reply_b), 32'(want.reply_b));
      cmp_field("payload_valid", 32'(got.pay_v), 32'(want.pay_v));
      cmp_field("payload_byte", 32'(got.pay_b), 32'(want.pay_b));
      cmp_field("verdict", 32'(got.vrd), 32'(want.vrd));
      cmp_field("bytes_committed", got.total, want.total);
      cmp_field("session_state", 32'(got.state), 32'(want.state));
      cmp_field("last", 32'(got.last), 32'(want.last));
    endtask

    task check_leftover();
      if (due.size() != 0)
        report($sformatf("%0d expected results never arrived", due.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_START;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        reply_valid;
  logic [7:0]  reply_byte;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [1:0]  verdict;
  logic [31:0] bytes_committed;
  logic [2:0]  session_state;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  error_limit = ERROR_LIMIT_RESET;

  ymodem_data_receiver u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .reply_valid     (reply_valid),
    .reply_byte      (reply_byte),
    .payload_valid   (payload_valid),
    .payload_byte    (payload_byte),
    .verdict         (verdict),
    .bytes_committed (bytes_committed),
    .session_state   (session_state),
    .last            (last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .error_limit     (error_limit)
  );

  receiver_scoreboard sb = new();

  int gap_top   = WAIT_TOP;   // sender: max cycles between command transactions
  int stall_top = 0;          // receiver: max cycles out_ready is held low
  int quiet_cycles = 0;
  int limit_writes = 0;
  int sessions     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: per result, draw a stall, then hold ready until a transaction.
  always begin : result_sink
    int stall;
    stall = $urandom_range(0, stall_top);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && out_ready));
  end

  // Compare every result transaction. Sampled at the edge, before the NBA
  // updates of that edge land, so DUT and testbench agree on what was moved.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_output({reply_valid, reply_byte, payload_valid, payload_byte, verdict,
                       bytes_committed, session_state, last});
  end

  // Watchdog: the run is hung if no channel moves anything while quiet_cycles climbs to IDLE_LIMIT.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command driver. Called at a clock edge; returns at the edge where the
  // command transaction happens. With no gap, valid simply stays high and
  // only the payload changes.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_top);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, b);
  endtask

  // Write error_limit only with the receiver drained: all owed results in,
  // then a few more cycles for commands that produce no result.
  task automatic write_error_limit(input logic [4:0] val);
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid   <= 1'b1;
    error_limit <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sb.err_limit = val;
    limit_writes++;
  endtask

  // One framed block: header, number, complement, data, CRC (big-endian).
  // The kind decides what is wrong with it, if anything.
  task automatic send_block(input block_kind_t kind, input bit is_long);
    logic [7:0]  frame[$];
    logic [7:0]  num, cmp, d;
    logic [15:0] crc;
    int          len, count;
    len = is_long ? LONG_LEN : SHORT_LEN;
    num = sb.want_blk;
    case (kind)
      BK_HEADER: num = 8'h00;
      BK_DUP:    num = sb.want_blk - 8'd1;
      BK_WRONG_NUM: begin
        do num = 8'($urandom);
        while (num == sb.want_blk || num == sb.want_blk - 8'd1 || num == 8'h00);
      end
      default: ;
    endcase
    cmp = ~num;
    if (kind == BK_BAD_CMP) cmp = cmp ^ 8'($urandom_range(1, 255));
    frame.push_back(is_long ? CH_STX : CH_SOH);
    frame.push_back(num);
    frame.push_back(cmp);
    crc = '0;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      crc = receiver_scoreboard::crc_step(crc, d);
      frame.push_back(d);
    end
    if (kind == BK_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    // a timed-out block is cut just after the header or later; a long one within its first 24 bytes
    count = frame.size();
    if (kind == BK_TIMEOUT) count = $urandom_range(1, is_long ? 24 : frame.size() - 1);
    for (int i = 0; i < count; i++) send_item(CMD_BYTE, frame[i]);
    if (kind == BK_TIMEOUT) send_item(CMD_TIMEOUT, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    block_kind_t kind_deck[$];
    block_kind_t kind;
    int          start_count, nblocks, blk, r, extra;
    bit          long_done, is_long;
    logic [4:0]  lim;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset value of error_limit (5).
    // Commands before any session are dropped, as is the reserved command.
    send_item(CMD_BYTE, CH_SOH);
    send_item(CMD_TIMEOUT, 8'hFF);
    send_item(CMD_UNUSED, 8'h00);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_UNUSED, 8'hA5);
    // five errors: bad start bytes at both extremes, idle timeout,
    // lone CA followed by data, timeout inside a block header
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_BYTE, CH_CAN);
    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_BYTE, CH_STX);
    send_item(CMD_BYTE, 8'h01);
    send_item(CMD_TIMEOUT, 8'h00);
    // sixth error passes the limit: CA CA, too many errors; EOT then ignored
    send_item(CMD_BYTE, 8'h7E);
    send_item(CMD_BYTE, CH_EOT);
    // local abort, both spellings
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, CH_ABORT);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, CH_ABORT_LC);
    // sender cancel
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, CH_CAN);
    send_item(CMD_BYTE, CH_CAN);
    // restart while receiving, then end of transmission
    send_item(CMD_START, 8'h00);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, CH_EOT);

    // Random part: well-formed sessions of blocks with random content, with
    // broken blocks and stray bytes mixed in. The first blocks walk through
    // every block kind once; later ones are drawn with weights.
    kind_deck   = '{BK_GOOD, BK_HEADER, BK_DUP, BK_WRONG_NUM, BK_BAD_CMP, BK_BAD_CRC,
                    BK_TIMEOUT};
    long_done   = 1'b0;
    start_count = sb.taken;
    while (sb.taken < start_count + RANDOM_ITEMS) begin
      // retune error_limit every third session: 1, 31, random, reset value
      if (sessions % 3 == 0) begin
        case ((sessions / 3) % 4)
          0:       lim = 5'd1;
          1:       lim = 5'd31;
          2:       lim = 5'($urandom_range(1, 31));
          default: lim = ERROR_LIMIT_RESET;
        endcase
        write_error_limit(lim);
      end
      // each side idles or runs flat out for a whole session
      gap_top   = ($urandom_range(0, 3) == 0) ? 0 : WAIT_TOP;
      stall_top = ($urandom_range(0, 3) == 0) ? 0 : WAIT_TOP;

      send_item(CMD_START, 8'($urandom));
      nblocks = $urandom_range(1, 6);
      for (blk = 0; blk < nblocks && sb.phase == PH_RECEIVING; blk++) begin
        // occasional line noise between blocks
        if ($urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 4))
            0: send_item(CMD_BYTE, 8'($urandom));
            1: send_item(CMD_TIMEOUT, 8'($urandom));
            2: send_item(CMD_UNUSED, 8'($urandom));
            3: begin
              send_item(CMD_BYTE, CH_CAN);
              send_item(CMD_BYTE, 8'($urandom));
            end
            default: send_item(CMD_START, 8'($urandom));
          endcase
          if (sb.phase != PH_RECEIVING) break;
        end
        if (kind_deck.size() != 0) begin
          kind = kind_deck.pop_front();
        end else begin
          r = $urandom_range(0, 99);
          kind = (r < 50) ? BK_GOOD : (r < 60) ? BK_HEADER : (r < 70) ? BK_DUP :
                 (r < 78) ? BK_WRONG_NUM : (r < 86) ? BK_BAD_CMP :
                 (r < 94) ? BK_BAD_CRC : BK_TIMEOUT;
        end
        // one full 1024-byte block is enough; truncated ones are cheap
        is_long = (kind == BK_GOOD && !long_done && sessions >= 1) ||
                  (kind == BK_TIMEOUT && $urandom_range(0, 1) == 1);
        if (kind == BK_GOOD && is_long) long_done = 1'b1;
        send_block(kind, is_long);
      end

      if (sb.phase == PH_RECEIVING) begin
        case ($urandom_range(0, 5))
          0, 1, 2: send_item(CMD_BYTE, CH_EOT);
          3: begin
            send_item(CMD_BYTE, CH_CAN);
            send_item(CMD_BYTE, CH_CAN);
          end
          4: send_item(CMD_BYTE, $urandom_range(0, 1) ? CH_ABORT : CH_ABORT_LC);
          default: ;   // left open; the next start restarts it
        endcase
      end
      // traffic after the session has ended must be dropped
      if (sb.phase != PH_RECEIVING && $urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, 3);
        repeat (extra) send_item(2'($urandom_range(1, 3)), 8'($urandom));
      end
      sessions++;
    end

    // Drain: everything owed, then DRAIN_CYCLES quiet cycles.
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftover();

    $display("Run covered %0d commands and %0d results over %0d random sessions",
             sb.taken, sb.checked, sessions);
    $display("Blocks: %0d committed, %0d discarded, %0d header repeats; %0d limit writes",
             sb.commits, sb.discards, sb.headers, limit_writes);
    if (sb.fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
